FILE: rtl/mcof_pkg.sv
// package for the multi-channel overwrite fifo
// holds the item structs, operation and status codes and parameter defaults
// no dependencies
`timescale 1ns / 1ps

package mcof_pkg;

  localparam int NUM_CHANNELS_DEF  = 4;
  localparam int CHANNEL_DEPTH_DEF = 16;
  localparam int WORD_WIDTH_DEF    = 32;

  // address bus width wide enough for the largest store (64 channels x 1024 words)
  localparam int MEM_ADDR_W = 16;

  localparam logic [1:0] KIND_INIT  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [1:0] ST_OVERWRITE = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  chan_idx;
    logic [31:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_data;
    logic [4:0]  fill_level;
    logic [31:0] lost_count;
  } out_item_t;

  // result of the channel update, read data joins later from the store
  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  fill_level;
    logic [31:0] lost_count;
    logic        rd_ok;
  } mcof_res_t;

  typedef struct packed {
    logic                  wr_en;
    logic                  rd_en;
    logic [MEM_ADDR_W-1:0] addr;
    logic [31:0]           wdata;
  } mcof_mem_req_t;

endpackage

FILE: rtl/mcof_ram.sv
// generic single-port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module mcof_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/mcof_chan_ctrl.sv
// per-channel head, tail, fill count and lost counter with the update logic
// depends on mcof_pkg
`timescale 1ns / 1ps

module mcof_chan_ctrl #(
  parameter int NUM_CHANNELS  = mcof_pkg::NUM_CHANNELS_DEF,
  parameter int CHANNEL_DEPTH = mcof_pkg::CHANNEL_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  mcof_pkg::in_item_t     in_item,
  output mcof_pkg::mcof_res_t    res,
  output mcof_pkg::mcof_mem_req_t mem_req
);
  import mcof_pkg::*;

  localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int PTR_W = $clog2(CHANNEL_DEPTH);
  localparam int CNT_W = $clog2(CHANNEL_DEPTH + 1);

  logic [PTR_W-1:0] head_r [NUM_CHANNELS];
  logic [PTR_W-1:0] tail_r [NUM_CHANNELS];
  logic [CNT_W-1:0] cnt_r  [NUM_CHANNELS];
  logic [31:0]      lost_r [NUM_CHANNELS];

  logic [PTR_W-1:0] head_nxt, tail_nxt, cur_head, cur_tail;
  logic [CNT_W-1:0] cnt_nxt, cur_cnt;
  logic [31:0]      lost_nxt, cur_lost;
  logic [CH_W-1:0]  ch;
  logic             bad_idx;
  logic             upd;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(CHANNEL_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [MEM_ADDR_W-1:0] slot_addr(input logic [CH_W-1:0] c,
                                                      input logic [PTR_W-1:0] p);
    slot_addr = MEM_ADDR_W'(c) * MEM_ADDR_W'(CHANNEL_DEPTH) + MEM_ADDR_W'(p);
  endfunction

  assign bad_idx  = {1'b0, in_item.chan_idx} >= 9'(NUM_CHANNELS);
  assign ch       = in_item.chan_idx[CH_W-1:0];
  assign cur_head = head_r[ch];
  assign cur_tail = tail_r[ch];
  assign cur_cnt  = cnt_r[ch];
  assign cur_lost = lost_r[ch];

  always_comb begin
    head_nxt      = cur_head;
    tail_nxt      = cur_tail;
    cnt_nxt       = cur_cnt;
    lost_nxt      = cur_lost;
    res.status    = ST_OK;
    res.rd_ok     = 1'b0;
    mem_req.wr_en = 1'b0;
    mem_req.rd_en = 1'b0;
    mem_req.addr  = slot_addr(ch, cur_head);
    mem_req.wdata = in_item.write_data;
    upd           = in_valid && !bad_idx;

    case (in_item.kind)
      KIND_INIT: begin
        head_nxt = '0;
        tail_nxt = '0;
        cnt_nxt  = '0;
        lost_nxt = '0;
      end
      KIND_READ: begin
        if (cur_cnt == '0) begin
          res.status = ST_EMPTY;
        end else begin
          mem_req.rd_en = upd;
          res.rd_ok     = 1'b1;
          head_nxt      = ptr_inc(cur_head);
          cnt_nxt       = cur_cnt - 1'b1;
        end
      end
      KIND_WRITE: begin
        mem_req.wr_en = upd;
        mem_req.addr  = slot_addr(ch, cur_tail);
        tail_nxt      = ptr_inc(cur_tail);
        if (cur_cnt >= CNT_W'(CHANNEL_DEPTH)) begin
          // full: oldest word goes, head follows the tail
          lost_nxt   = cur_lost + 32'd1;
          head_nxt   = ptr_inc(cur_head);
          res.status = ST_OVERWRITE;
        end else begin
          cnt_nxt = cur_cnt + 1'b1;
        end
      end
      default: begin
      end
    endcase

    res.fill_level = 5'(cnt_nxt);
    res.lost_count = lost_nxt;
    if (bad_idx) begin
      res.status     = ST_BAD_INDEX;
      res.fill_level = '0;
      res.lost_count = '0;
      res.rd_ok      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i]  <= '0;
        lost_r[i] <= '0;
      end
    end else if (upd) begin
      head_r[ch] <= head_nxt;
      tail_r[ch] <= tail_nxt;
      cnt_r[ch]  <= cnt_nxt;
      lost_r[ch] <= lost_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !bad_idx |-> cur_cnt <= CNT_W'(CHANNEL_DEPTH))
    else $error("channel fill count above depth");

  a_ovw_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && res.status == ST_OVERWRITE |-> cur_cnt == CNT_W'(CHANNEL_DEPTH))
    else $error("overwrite reported on a channel that is not full");

  a_single_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_req.wr_en && mem_req.rd_en))
    else $error("store read and written by one item");

  a_empty_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && res.status == ST_EMPTY |-> cnt_nxt == cur_cnt && head_nxt == cur_head)
    else $error("read on empty changed the channel");

endmodule

FILE: rtl/multi_channel_overwrite_fifo.sv
// multi-channel overwrite fifo: a bank of ring buffers that share one word store.
// An item (kind, chan_idx, write_data) is taken at a rising edge with start high
// and busy low. busy is never raised, so one item can be taken in every cycle.
// kind init clears the channel, read pops the oldest word, write appends a word;
// a write to a full channel replaces the oldest word and bumps the lost counter.
// Each item gives exactly one result on out_item, marked by out_valid for one cycle,
// after the input register and then the result register and the registered read port
// of the word store. The receiver cannot stall; results come in item order at one
// per cycle, the rate set by the single port of the word store and the registered
// pointer update of the selected channel.
// Reset (rst_n low, synchronous) empties every channel and zeroes all lost counters;
// the word store itself is not cleared, and a word is only read after it is written.
// Channel numbers at or above the channel count return bad-index status and change
// nothing. Depends on mcof_pkg, mcof_chan_ctrl and mcof_ram.
`timescale 1ns / 1ps

module multi_channel_overwrite_fifo #(
  parameter int NUM_CHANNELS  = mcof_pkg::NUM_CHANNELS_DEF,
  parameter int CHANNEL_DEPTH = mcof_pkg::CHANNEL_DEPTH_DEF,
  parameter int WORD_WIDTH    = mcof_pkg::WORD_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  mcof_pkg::in_item_t  in_item,
  output logic                out_valid,
  output mcof_pkg::out_item_t out_item
);
  import mcof_pkg::*;

  localparam int STORE_WORDS = NUM_CHANNELS * CHANNEL_DEPTH;
  localparam int AW          = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;

  logic            in_valid_r;
  in_item_t        in_item_r;
  mcof_res_t       res;
  mcof_res_t       res_r;
  mcof_mem_req_t   mem_req;
  logic            out_valid_r;
  logic [WORD_WIDTH-1:0] rdata;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= start && !busy;
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    in_item_r <= in_item;
    res_r     <= res;
  end

  mcof_chan_ctrl #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .CHANNEL_DEPTH(CHANNEL_DEPTH)
  ) u_chan_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid_r),
    .in_item (in_item_r),
    .res     (res),
    .mem_req (mem_req)
  );

  mcof_ram #(
    .WIDTH(WORD_WIDTH),
    .DEPTH(STORE_WORDS),
    .AW   (AW)
  ) u_word_store (
    .clk  (clk),
    .we   (mem_req.wr_en),
    .re   (mem_req.rd_en),
    .addr (AW'(mem_req.addr)),
    .wdata(WORD_WIDTH'(mem_req.wdata)),
    .rdata(rdata)
  );

  assign out_valid           = out_valid_r;
  assign out_item.status     = res_r.status;
  assign out_item.read_data  = res_r.rd_ok ? 32'(rdata) : 32'd0;
  assign out_item.fill_level = res_r.fill_level;
  assign out_item.lost_count = res_r.lost_count;

  a_two_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> ##1 out_valid)
    else $error("item did not give a result two cycles later");

  a_rd_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != ST_OK |-> out_item.read_data == 32'd0)
    else $error("read data on a result that is not a good read");

endmodule

FILE: tb/sv/tb_multi_channel_overwrite_fifo.sv
// testbench for multi_channel_overwrite_fifo: directed and random init, read and write items
// checked against a per-channel ring buffer model kept in a small scoreboard class
// depends on mcof_pkg and the multi_channel_overwrite_fifo rtl
`timescale 1ns / 1ps

module tb_multi_channel_overwrite_fifo;
  import mcof_pkg::*;

  localparam int NCH   = NUM_CHANNELS_DEF;
  localparam int DEPTH = CHANNEL_DEPTH_DEF;
  // kind value with no operation behind it
  localparam logic [1:0] KIND_NOP = 2'd3;
  localparam int RAND_PER_PHASE = 475;

  class fifo_bank_board;
    logic [31:0] word_mem[NCH*DEPTH];
    int          head_ptr[NCH];
    int          tail_ptr[NCH];
    int          word_cnt[NCH];
    logic [31:0] lost_cnt[NCH];
    out_item_t   pending_results[$];
    int          errors;
    int          n_items, n_ok_reads, n_writes, n_over, n_empty, n_bad, n_inits;

    function new();
      for (int c = 0; c < NCH; c++) begin
        head_ptr[c] = 0;
        tail_ptr[c] = 0;
        word_cnt[c] = 0;
        lost_cnt[c] = '0;
      end
      errors = 0;
      n_items = 0; n_ok_reads = 0; n_writes = 0; n_over = 0;
      n_empty = 0; n_bad = 0; n_inits = 0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // work out the result of one accepted item and update the channel copy
    function void note_item(in_item_t it);
      out_item_t res;
      int ch;
      res = '0;
      ch = it.chan_idx;
      n_items++;
      if (ch >= NCH) begin
        res.status = ST_BAD_INDEX;
        n_bad++;
      end else begin
        case (it.kind)
          KIND_INIT: begin
            head_ptr[ch] = 0;
            tail_ptr[ch] = 0;
            word_cnt[ch] = 0;
            lost_cnt[ch] = '0;
            n_inits++;
          end
          KIND_READ: begin
            if (word_cnt[ch] == 0) begin
              res.status = ST_EMPTY;
              n_empty++;
            end else begin
              res.read_data = word_mem[ch*DEPTH + head_ptr[ch]];
              head_ptr[ch] = (head_ptr[ch] + 1) % DEPTH;
              word_cnt[ch]--;
              n_ok_reads++;
            end
          end
          KIND_WRITE: begin
            word_mem[ch*DEPTH + tail_ptr[ch]] = it.write_data;
            if (word_cnt[ch] >= DEPTH) begin
              // full: oldest word is gone, head follows the tail
              lost_cnt[ch] = lost_cnt[ch] + 32'd1;
              head_ptr[ch] = (head_ptr[ch] + 1) % DEPTH;
              res.status = ST_OVERWRITE;
              n_over++;
            end else begin
              word_cnt[ch]++;
            end
            tail_ptr[ch] = (tail_ptr[ch] + 1) % DEPTH;
            n_writes++;
          end
          default: ;
        endcase
        res.fill_level = word_cnt[ch][4:0];
        res.lost_count = lost_cnt[ch];
      end
      pending_results.push_back(res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result with no item waiting: %p", $time, got);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.read_data !== want.read_data) begin
        $display("%0t: read_data expected %h actual %h", $time, want.read_data, got.read_data);
        errors++;
      end
      if (got.fill_level !== want.fill_level) begin
        $display("%0t: fill_level expected %0d actual %0d", $time, want.fill_level,
                 got.fill_level);
        errors++;
      end
      if (got.lost_count !== want.lost_count) begin
        $display("%0t: lost_count expected %0d actual %0d", $time, want.lost_count,
                 got.lost_count);
        errors++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  fifo_bank_board board;

  multi_channel_overwrite_fifo u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && start && !busy) board.note_item(in_item);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_result(out_item);
  end

  // hold an item on the port until it is taken, with random gaps before it
  task automatic send(input logic [1:0] kind, input logic [7:0] idx,
                      input logic [31:0] data, input int idle_pct);
    in_item_t it;
    it.kind = kind;
    it.chan_idx = idx;
    it.write_data = data;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    send(KIND_INIT, 8'd3, 32'h0, 0);
    send(KIND_READ, 8'd1, 32'h0, 0);
    send(KIND_WRITE, 8'd0, 32'h0000_0000, 0);
    send(KIND_WRITE, 8'd0, 32'hffff_ffff, 0);
    // fill channel 0 and go one past full
    for (int i = 0; i < DEPTH - 1; i++) send(KIND_WRITE, 8'd0, $urandom, 0);
    send(KIND_WRITE, 8'd4, 32'h1234_5678, 0);
    send(KIND_READ, 8'd255, 32'hffff_ffff, 0);
    send(KIND_NOP, 8'd2, $urandom, 0);
    send(KIND_NOP, 8'd200, $urandom, 0);
    send(KIND_READ, 8'd0, 32'h0, 0);
    send(KIND_INIT, 8'd0, 32'h0, 0);
    send(KIND_READ, 8'd0, 32'h0, 0);
  endtask

  // blocks of items aimed mostly at one channel, filling, draining or mixed
  task automatic run_random(input int n_total, input int idle_pct);
    int left, blk, mode, focus, r, w;
    logic [1:0]  kind;
    logic [7:0]  idx;
    logic [31:0] data;
    left = n_total;
    while (left > 0) begin
      blk = $urandom_range(60, 30);
      r = $urandom_range(99);
      mode = (r < 45) ? 0 : (r < 80) ? 1 : 2;
      focus = $urandom_range(NCH - 1);
      for (int i = 0; i < blk && left > 0; i++) begin
        r = $urandom_range(99);
        if (r < 6) idx = 8'($urandom_range(255));
        else if (r < 90) idx = 8'(focus);
        else idx = 8'($urandom_range(NCH - 1));
        w = $urandom_range(99);
        case (mode)
          0: kind = (w < 78) ? KIND_WRITE : (w < 93) ? KIND_READ : (w < 95) ? KIND_INIT
                                                                           : KIND_NOP;
          1: kind = (w < 48) ? KIND_WRITE : (w < 92) ? KIND_READ : (w < 96) ? KIND_INIT
                                                                           : KIND_NOP;
          default: kind = (w < 15) ? KIND_WRITE : (w < 93) ? KIND_READ : (w < 95) ? KIND_INIT
                                                                                  : KIND_NOP;
        endcase
        r = $urandom_range(19);
        data = (r == 0) ? 32'h0 : (r == 1) ? 32'hffff_ffff : $urandom;
        send(kind, idx, data, idle_pct);
        left--;
      end
    end
  endtask

  initial begin
    int phase_idle[4];
    board = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    // the receiver cannot stall, so the third phase runs back to back like the first
    phase_idle = '{0, 78, 0, 37};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    wait_drained();
    for (int p = 0; p < 4; p++) begin
      run_random(RAND_PER_PHASE, phase_idle[p]);
      wait_drained();
    end
    repeat (8) @(posedge clk);
    $display("covered %0d items: %0d writes (%0d overwrites), %0d good reads, %0d empty reads",
             board.n_items, board.n_writes, board.n_over, board.n_ok_reads, board.n_empty);
    $display("  %0d channel inits, %0d bad channel numbers, %0d mismatches",
             board.n_inits, board.n_bad, board.errors);
    if (board.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
